### rtl/block_arithmetic_decoder_unit_defines.svh
// Assertion macros for the arithmetic decoder.
`ifndef BLOCK_ARITHMETIC_DECODER_UNIT_DEFINES_SVH
`define BLOCK_ARITHMETIC_DECODER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BAD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion lbl failed");
`define BAD_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("assertion lbl failed");
`else
`define BAD_ASSERT(lbl, clk, rstn, prop)
`define BAD_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### rtl/bad_pkg.sv
// Shared types and constants of the arithmetic decoder.
`default_nettype none
package bad_pkg;
  localparam int unsigned BLOCK_BYTES_DEF       = 7;
  localparam int unsigned MAX_BLOCK_SYMBOLS_DEF = 64;
  localparam int unsigned ALPHABET_DEF          = 256;
  localparam int unsigned FRAC_BITS             = 60;

  localparam logic OP_TABLE = 1'b0;
  localparam logic OP_CODE  = 1'b1;

  localparam logic REG_BLOCK_SYMBOLS = 1'b0;
  localparam logic REG_TOTAL_SYMBOLS = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_DIV,
    ST_MUL,
    ST_CMP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic        en;
    logic [7:0]  addr;
    logic [31:0] cum;
    logic [31:0] cnt;
  } tbl_wr_t;
endpackage
`default_nettype wire

### rtl/bad_table.sv
// Interval table memory with per-entry valid flags.
`default_nettype none
module bad_table import bad_pkg::*; #(
  parameter int unsigned ALPHABET = ALPHABET_DEF,
  parameter int unsigned IDX_W    = $clog2(ALPHABET)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire tbl_wr_t          wr_i,
  input  wire logic             rd_en_i,
  input  wire logic [IDX_W-1:0] rd_addr_i,
  output logic      [31:0]      rd_cum_o,
  output logic      [31:0]      rd_cnt_o,
  output logic                  rd_valid_o
);
  logic [63:0]         mem [ALPHABET];
  logic [ALPHABET-1:0] valid_q;
  logic [63:0]         rd_data_q;
  logic                rd_valid_q;
  logic [IDX_W-1:0]    wr_idx;

  assign wr_idx = wr_i.addr[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_idx] <= {wr_i.cum, wr_i.cnt};
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_cum_o   = rd_data_q[63:32];
  assign rd_cnt_o   = rd_data_q[31:0];
  assign rd_valid_o = rd_valid_q;
endmodule
`default_nettype wire

### rtl/bad_fxdiv.sv
// Bit-serial fixed-point divider: floor(num * 2^60 / den), saturating.
`default_nettype none
module bad_fxdiv import bad_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [32:0] num_i,
  input  wire logic [31:0] den_i,
  output logic             done_o,
  output logic [63:0]      quo_o
);
  localparam int unsigned STEPS = 33 + FRAC_BITS;

  logic        busy_q, busy_d, done_q, done_d, ovf_q, ovf_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [32:0] num_q, num_d;
  logic [31:0] rem_q, rem_d, den_q, den_d;
  logic [63:0] quo_q, quo_d;
  logic [32:0] r2;
  logic        ge;

  assign r2 = {rem_q, num_q[32]};
  assign ge = r2 >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    ovf_d  = ovf_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      ovf_d  = 1'b0;
      cnt_d  = '0;
      num_d  = num_i;
      rem_d  = '0;
      den_d  = (den_i == '0) ? 32'd1 : den_i;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? 32'(r2 - {1'b0, den_q}) : r2[31:0];
      num_d = {num_q[31:0], 1'b0};
      quo_d = {quo_q[62:0], ge};
      ovf_d = ovf_q | quo_q[63];
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'(STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ovf_q <= ovf_d;
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = ovf_q ? '1 : quo_q;
endmodule
`default_nettype wire

### rtl/bad_fxmul.sv
// Multi-cycle fixed-point multiplier: floor(a * b / 2^60), saturating.
`default_nettype none
module bad_fxmul import bad_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic             done_o,
  output logic [63:0]      prod_o
);
  logic         busy_q, busy_d, done_q, done_d;
  logic [1:0]   sel_q, sel_d;
  logic [63:0]  a_q, a_d, b_q, b_d;
  logic [127:0] acc_q, acc_d, part;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;

  assign pa = sel_q[0] ? a_q[63:32] : a_q[31:0];
  assign pb = sel_q[1] ? b_q[63:32] : b_q[31:0];
  assign pp = pa * pb;

  always_comb begin
    unique case (sel_q)
      2'd0:    part = {64'd0, pp};
      2'd3:    part = {pp, 64'd0};
      default: part = {32'd0, pp, 32'd0};
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    sel_d  = sel_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      sel_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = acc_q + part;
      sel_d = sel_q + 2'd1;
      if (sel_q == 2'd3) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sel_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      sel_q  <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = (acc_q[127:124] != '0) ? '1 : acc_q[123:60];
endmodule
`default_nettype wire

### rtl/block_arithmetic_decoder_unit.sv
// Top level of the static-model arithmetic decoder.
// Table words (op 0) are taken in one cycle each and written to the interval
// memory. Code words (op 1) are taken in one cycle each; the last word of a
// block starts decoding if symbols are left, during which in_ready_o is low.
// Each decode step scans the table one entry at a time; an empty entry passes
// through the read and check states, and every valid entry it visits also
// costs two serial divisions, two multiplications and a compare. Results wait
// in an output register; a step holds until that register is free.
`default_nettype none
`include "block_arithmetic_decoder_unit_defines.svh"
module block_arithmetic_decoder_unit import bad_pkg::*; #(
  parameter int unsigned BLOCK_BYTES       = BLOCK_BYTES_DEF,
  parameter int unsigned MAX_BLOCK_SYMBOLS = MAX_BLOCK_SYMBOLS_DEF,
  parameter int unsigned ALPHABET          = ALPHABET_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        op_i,
  input  wire logic [7:0]  symbol_i,
  input  wire logic [31:0] count_i,
  input  wire logic [7:0]  code_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       decoded_symbol_o,
  output logic             found_o,
  output logic             last_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int unsigned IDX_W = $clog2(ALPHABET);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [6:0]       step_q, step_d, bsym_q, bsym_d, n_eff;
  logic             phase_q, phase_d, hit_q, hit_d;
  logic [63:0]      l_q, l_d, h_q, h_d, l1_q, l1_d, h1_q, h1_d;
  logic [59:0]      code_q, code_d, code_new;
  logic [2:0]       bib_q, bib_d;
  logic [31:0]      cum_q, cum_d, left_q, left_d, total_q, total_d;
  logic             out_valid_q, out_valid_d, found_q, found_d, last_q, last_d;
  logic [7:0]       osym_q, osym_d;

  tbl_wr_t     tbl_wr;
  logic        rd_en, rd_valid;
  logic [31:0] rd_cum, rd_cnt;
  logic        div_start, div_done, mul_start, mul_done;
  logic [32:0] div_num, cum_next;
  logic [63:0] div_quo, mul_prod, range, end_sat;
  logic [64:0] end_sum;
  logic [7:0]  rev;
  logic [63:0] code_sh;
  logic        in_acc, cfg_we, out_free, idx_last, code_in, last_now, blk_end;

  bad_table #(.ALPHABET(ALPHABET), .IDX_W(IDX_W)) u_table (
    .clk_i, .rst_ni, .wr_i(tbl_wr), .rd_en_i(rd_en), .rd_addr_i(idx_q),
    .rd_cum_o(rd_cum), .rd_cnt_o(rd_cnt), .rd_valid_o(rd_valid)
  );

  bad_fxdiv u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(total_q),
    .done_o(div_done), .quo_o(div_quo)
  );

  bad_fxmul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(div_quo), .b_i(range),
    .done_o(mul_done), .prod_o(mul_prod)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign cfg_we     = psel && penable && pwrite;
  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == REG_BLOCK_SYMBOLS) ? {25'd0, bsym_q} : total_q;
  assign out_free   = !out_valid_q || out_ready_i;
  assign idx_last   = (idx_q == IDX_W'(ALPHABET - 1));
  assign range      = (h_q >= l_q) ? h_q - l_q : '0;
  assign end_sum    = {1'b0, l_q} + {1'b0, mul_prod};
  assign end_sat    = end_sum[64] ? '1 : end_sum[63:0];
  assign div_num    = phase_d ? ({1'b0, rd_cum} + {1'b0, rd_cnt}) : {1'b0, rd_cum};
  assign cum_next   = {1'b0, cum_q} + {1'b0, count_i};
  assign n_eff      = (bsym_q == '0) ? 7'd1 :
                      (bsym_q > 7'(MAX_BLOCK_SYMBOLS)) ? 7'(MAX_BLOCK_SYMBOLS) : bsym_q;
  assign last_now   = ((step_q + 7'd1) == n_eff) || (left_q == '0);
  assign code_in    = in_acc && (op_i == OP_CODE);
  assign blk_end    = ({1'b0, bib_q} + 4'd1) >= 4'(BLOCK_BYTES);
  assign hit_d      = (l1_q <= {4'd0, code_q}) && ({4'd0, code_q} < h1_q);

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      rev[j] = code_byte_i[7-j];
    end
  end
  assign code_sh  = ({rev, 56'd0} >> {bib_q, 3'd0}) >> 4;
  assign code_new = code_q | code_sh[59:0];

  always_comb begin
    tbl_wr.en   = in_acc && (op_i == OP_TABLE) && ({1'b0, symbol_i} < 9'(ALPHABET));
    tbl_wr.addr = symbol_i;
    tbl_wr.cum  = cum_q;
    tbl_wr.cnt  = count_i;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (code_in && blk_end && left_q != '0) state_d = ST_READ;
      ST_READ:  state_d = ST_CHECK;
      ST_CHECK: begin
        if (rd_valid) state_d = ST_DIV;
        else if (idx_last) state_d = ST_EMIT;
        else state_d = ST_READ;
      end
      ST_DIV:   if (div_done) state_d = ST_MUL;
      ST_MUL:   if (mul_done) state_d = phase_q ? ST_CMP : ST_DIV;
      ST_CMP: begin
        if (hit_d || idx_last) state_d = ST_EMIT;
        else state_d = ST_READ;
      end
      ST_EMIT:  if (out_free) state_d = last_now ? ST_IDLE : ST_READ;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en       = (state_q == ST_READ);
    div_start   = 1'b0;
    mul_start   = 1'b0;
    idx_d       = idx_q;
    step_d      = step_q;
    phase_d     = phase_q;
    l_d         = l_q;
    h_d         = h_q;
    l1_d        = l1_q;
    h1_d        = h1_q;
    code_d      = code_q;
    bib_d       = bib_q;
    cum_d       = cum_q;
    left_d      = left_q;
    bsym_d      = bsym_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && !out_ready_i;
    osym_d      = osym_q;
    found_d     = found_q;
    last_d      = last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (tbl_wr.en) begin
          cum_d = cum_next[32] ? '1 : cum_next[31:0];
        end
        if (code_in) begin
          if (blk_end) begin
            bib_d = '0;
            if (left_q == '0) begin
              code_d = '0;
            end else begin
              code_d = code_new;
              idx_d  = '0;
              step_d = '0;
              l_d    = '0;
              h_d    = 64'd1 << FRAC_BITS;
            end
          end else begin
            code_d = code_new;
            bib_d  = bib_q + 3'd1;
          end
        end
      end
      ST_CHECK: begin
        if (rd_valid) begin
          phase_d   = 1'b0;
          div_start = 1'b1;
        end else if (!idx_last) begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_DIV: begin
        mul_start = div_done;
      end
      ST_MUL: begin
        if (mul_done) begin
          if (phase_q) begin
            h1_d = end_sat;
          end else begin
            l1_d      = end_sat;
            phase_d   = 1'b1;
            div_start = 1'b1;
          end
        end
      end
      ST_CMP: begin
        if (hit_d) begin
          l_d    = l1_q;
          h_d    = h1_q;
          left_d = left_q - 32'd1;
        end else if (!idx_last) begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          osym_d      = hit_q ? 8'(idx_q) : 8'd0;
          found_d     = hit_q;
          last_d      = last_now;
          if (last_now) begin
            code_d = '0;
          end else begin
            step_d = step_q + 7'd1;
            idx_d  = '0;
          end
        end
      end
      default: begin
      end
    endcase
    if (cfg_we) begin
      if (paddr[2] == REG_BLOCK_SYMBOLS) begin
        bsym_d = pwdata[6:0];
      end else begin
        total_d = pwdata;
        left_d  = pwdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      code_q      <= '0;
      bib_q       <= '0;
      cum_q       <= '0;
      left_q      <= 32'd1;
      bsym_q      <= 7'd8;
      total_q     <= 32'd1;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      code_q      <= code_d;
      bib_q       <= bib_d;
      cum_q       <= cum_d;
      left_q      <= left_d;
      bsym_q      <= bsym_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_CHECK) begin
        hit_q <= 1'b0;
      end else if (state_q == ST_CMP) begin
        hit_q <= hit_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    step_q  <= step_d;
    phase_q <= phase_d;
    l_q     <= l_d;
    h_q     <= h_d;
    l1_q    <= l1_d;
    h1_q    <= h1_d;
    osym_q  <= osym_d;
    found_q <= found_d;
    last_q  <= last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign decoded_symbol_o = osym_q;
  assign found_o          = found_q;
  assign last_o           = last_q;

  `BAD_ASSERT(a_emit_holds, clk_i, rst_ni, (state_q == ST_EMIT) && !out_free |=> (state_q == ST_EMIT))
  `BAD_ASSERT_NEVER(a_div_done_state, clk_i, rst_ni, div_done && (state_q != ST_DIV))
  `BAD_ASSERT(a_left_nonincr, clk_i, rst_ni, !cfg_we |=> (left_q <= $past(left_q)))
  `BAD_ASSERT_NEVER(a_busy_ready, clk_i, rst_ni, in_ready_o && (rd_en || mul_start))
endmodule
`default_nettype wire
